FILE: hdl/vtpd_pkg.sv
// shared types and constants for the vertex transform block
package vtpd_pkg;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W = 64;
  localparam int unsigned COMP_W = 32;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned ACC_W = 66;
  localparam logic signed [COMP_W-1:0] COMP_MAX = 32'sh7fffffff;
  localparam logic signed [COMP_W-1:0] COMP_MIN = 32'sh80000000;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic  mode;
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } vtx_in_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
    logic  divide_by_zero;
    logic  saturated;
  } vtx_out_t;
endpackage

FILE: hdl/vtpd_if.sv
// valid/ready channel interface carrying one packed payload
interface vtpd_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/vertex_transform_perspective_divide.sv
// top level: 4x4 vertex transform with optional perspective divide
//  channel | dir | payload                               | handshake
//  in_     | in  | mode, in_x, in_y, in_z, in_w          | valid/ready
//  out_    | out | out_x..out_w, divide_by_zero, saturated| valid/ready
//  cfg_    | in  | 8 x 64-bit matrix registers, addr 8*i | apb, pready high
// one vertex per cycle sustained while the output is not stalled; the NQ = 31+FRAC_BITS
// quotient bits are set by the chain of division cells (one bit per cell)
// the whole pipeline advances together and stalls only when the output is
// full and not taken; rst_n clears valid bits and resets the matrix to identity
module vertex_transform_perspective_divide #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  vtpd_if.sink   in_ch,
  vtpd_if.source out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [vtpd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [vtpd_pkg::REG_W-1:0]  cfg_pwdata,
  output logic [vtpd_pkg::REG_W-1:0]  cfg_prdata,
  output logic                       cfg_pready
);
  import vtpd_pkg::*;

  localparam int unsigned NQ = 31 + FRAC_BITS;      // quotient bits kept
  localparam int unsigned NUM_W = 32 + FRAC_BITS;   // |r| << FRAC_BITS
  localparam int unsigned STAGES = 3 + NQ;          // product, sum, cells, out
  // 1.0 in the low or the high coefficient of a register
  localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
  localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << (32 + FRAC_BITS));

  // ---------------- configuration registers ----------------
  logic [REG_W-1:0] mat_r [NUM_REGS];
  logic [2:0] reg_idx;
  assign reg_idx = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = mat_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // identity: diagonal entries sit in registers 0, 2, 5 and 7
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i == 0 || i == 5) mat_r[i] <= ONE_LO;
        else if (i == 2 || i == 7) mat_r[i] <= ONE_HI;
        else mat_r[i] <= '0;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      mat_r[reg_idx] <= cfg_pwdata;
    end
  end

  function automatic comp_t coef(input logic [REG_W-1:0] r, input logic hi);
    return hi ? comp_t'(r[63:32]) : comp_t'(r[31:0]);
  endfunction

  // ---------------- pipeline control ----------------
  logic [STAGES-1:0] vld_r;
  logic adv;
  assign adv = !vld_r[STAGES-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[STAGES-2:0], in_ch.valid};
  end

  // ---------------- stage 1: sixteen products ----------------
  logic signed [63:0] prod_r [4][4];
  logic mode1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i][0] <= coef(mat_r[2*i], 1'b0) * in_ch.data.x;
        prod_r[i][1] <= coef(mat_r[2*i], 1'b1) * in_ch.data.y;
        prod_r[i][2] <= coef(mat_r[2*i+1], 1'b0) * in_ch.data.z;
        prod_r[i][3] <= coef(mat_r[2*i+1], 1'b1) * in_ch.data.w;
      end
      mode1_r <= in_ch.data.mode;
    end
  end

  // ---------------- stage 2: sum, shift, saturate, set up divide ----------------
  comp_t r_nxt [4];
  logic  sat_nxt;
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] sh;
    sat_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      acc = ACC_W'(prod_r[i][0]) + ACC_W'(prod_r[i][1])
          + ACC_W'(prod_r[i][2]) + ACC_W'(prod_r[i][3]);
      sh = acc >>> FRAC_BITS;
      if (sh > ACC_W'(COMP_MAX)) begin
        r_nxt[i] = COMP_MAX; sat_nxt = 1'b1;
      end else if (sh < ACC_W'(COMP_MIN)) begin
        r_nxt[i] = COMP_MIN; sat_nxt = 1'b1;
      end else begin
        r_nxt[i] = comp_t'(sh);
      end
    end
  end

  logic [NUM_W-1:0] rem0 [3];
  logic [NUM_W-1:0] quo0 [3];
  logic [31:0]      den0;
  comp_t            res_r [4];
  logic [2:0]       nneg_r;   // numerator negative
  logic [2:0]       nz_r;     // numerator zero
  logic             wneg_r, wz_r, mode2_r, sat2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r   <= r_nxt;
      mode2_r <= mode1_r;
      sat2_r  <= sat_nxt;
      wneg_r  <= r_nxt[3][31];
      wz_r    <= (r_nxt[3] == '0);
      for (int l = 0; l < 3; l++) begin
        nneg_r[l] <= r_nxt[l][31];
        nz_r[l]   <= (r_nxt[l] == '0);
      end
    end
  end

  // magnitudes entering the division chain
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem0[l] = NUM_W'(res_r[l][31] ? 33'(-34'(res_r[l])) : 33'(res_r[l])) << FRAC_BITS;
      quo0[l] = '0;
    end
    den0 = wneg_r ? 32'(-33'(res_r[3])) : 32'(res_r[3]);
  end

  // ---------------- division chain: one quotient bit per cell ----------------
  typedef struct packed {
    logic [3:0] mode_wz_wneg_sat;
    logic [2:0] nneg;
    logic [2:0] nz;
    comp_t      rx, ry, rz, rw;
  } side_t;

  logic [NUM_W-1:0] rem_c [NQ+1][3];
  logic [NUM_W-1:0] quo_c [NQ+1][3];
  logic [31:0]      den_c [NQ+1];
  side_t            side_c [NQ+1];

  assign rem_c[0] = rem0;
  assign quo_c[0] = quo0;
  assign den_c[0] = den0;
  assign side_c[0] = '{mode_wz_wneg_sat: {mode2_r, wz_r, wneg_r, sat2_r}, nneg: nneg_r,
                       nz: nz_r, rx: res_r[0], ry: res_r[1], rz: res_r[2], rw: res_r[3]};

  for (genvar k = 0; k < NQ; k++) begin : g_cell
    vtpd_div_cell #(.NUM_W(NUM_W), .DEN_W(32), .BIT_IDX(NQ-1-k)) u_cell (
      .clk(clk), .en(adv),
      .rem_i(rem_c[k]), .quo_i(quo_c[k]), .den_i(den_c[k]),
      .rem_o(rem_c[k+1]), .quo_o(quo_c[k+1]), .den_o(den_c[k+1])
    );
    side_t side_r;
    always_ff @(posedge clk) if (adv) side_r <= side_c[k];
    assign side_c[k+1] = side_r;
  end

  // ---------------- final stage: sign, clamp, select ----------------
  vtx_out_t res_nxt;
  always_comb begin
    side_t s;
    logic  sat;
    logic  neg;
    logic  [NUM_W-1:0] q;
    logic  [NUM_W:0] lim;
    comp_t outv [3];
    comp_t trn [3];
    logic  big;
    s = side_c[NQ];
    sat = s.mode_wz_wneg_sat[0];
    trn[0] = s.rx; trn[1] = s.ry; trn[2] = s.rz;
    for (int l = 0; l < 3; l++) begin
      q = quo_c[NQ][l];
      neg = s.nneg[l] ^ s.mode_wz_wneg_sat[1];
      lim = neg ? (NUM_W+1)'(33'h080000000) : (NUM_W+1)'(33'h07fffffff);
      // quotient bits above NQ can only be set if remainder-top is at least the denominator
      big = ((rem_c[NQ][l] >> NQ) >= NUM_W'(den_c[NQ])) || ({1'b0, q} > lim);
      if (s.mode_wz_wneg_sat[2]) begin
        outv[l] = s.nneg[l] ? COMP_MIN : (s.nz[l] ? '0 : COMP_MAX);
      end else if (big) begin
        outv[l] = neg ? COMP_MIN : COMP_MAX;
        sat = 1'b1;
      end else begin
        outv[l] = neg ? comp_t'(-q) : comp_t'(q);
      end
    end
    if (s.mode_wz_wneg_sat[3]) begin
      res_nxt.x = outv[0]; res_nxt.y = outv[1]; res_nxt.z = outv[2];
      res_nxt.w = comp_t'(64'd1 << FRAC_BITS);
      res_nxt.divide_by_zero = s.mode_wz_wneg_sat[2];
      res_nxt.saturated = sat;
    end else begin
      res_nxt.x = trn[0]; res_nxt.y = trn[1]; res_nxt.z = trn[2];
      res_nxt.w = s.rw;
      res_nxt.divide_by_zero = 1'b0;
      res_nxt.saturated = s.mode_wz_wneg_sat[0];
    end
  end

  vtx_out_t out_r;
  always_ff @(posedge clk) if (adv) out_r <= res_nxt;
  assign out_ch.data  = out_r;
  assign out_ch.valid = vld_r[STAGES-1];

  // ---------------- assertions ----------------
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready) else $error("input blocked with empty output");
  a_dz_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.divide_by_zero |-> out_ch.data.w == comp_t'(64'd1 << FRAC_BITS))
    else $error("divide by zero without unit w");
endmodule

FILE: hdl/vtpd_div_cell.sv
// one restoring-division cell: produces one quotient bit per cycle while en is high, for three lanes
module vtpd_div_cell #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned BIT_IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  rem_i [3],
  input  logic [NUM_W-1:0]  quo_i [3],
  input  logic [DEN_W-1:0]  den_i,
  output logic [NUM_W-1:0]  rem_o [3],
  output logic [NUM_W-1:0]  quo_o [3],
  output logic [DEN_W-1:0]  den_o
);
  logic [NUM_W-1:0] rem_nxt [3];
  logic [NUM_W-1:0] quo_nxt [3];
  logic [NUM_W-1:0] rem_r [3];
  logic [NUM_W-1:0] quo_r [3];
  logic [DEN_W-1:0] den_r;

  // trial subtract of den << BIT_IDX, compared on the upper part only
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_nxt[l] = rem_i[l];
      quo_nxt[l] = quo_i[l];
      if ((rem_i[l] >> BIT_IDX) >= NUM_W'(den_i)) begin
        rem_nxt[l] = rem_i[l] - (NUM_W'(den_i) << BIT_IDX);
        quo_nxt[l][BIT_IDX] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign den_o = den_r;
endmodule
